[sv/edid_detailed_timing_decode_defines.svh]
// Assertion macros shared by the EDID timing decoder checkers.
// No dependencies; take in with `include before use.
`ifndef EDID_DETAILED_TIMING_DECODE_DEFINES_SVH
`define EDID_DETAILED_TIMING_DECODE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define EDTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edtd check failed");

// next-cycle implication, disabled while reset is asserted
`define EDTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edtd check failed");

`endif

[sv/edtd_pkg.sv]
// Types and constants for the EDID detailed timing decoder.
// No dependencies; used by the top level and its checker.
package edtd_pkg;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_ZERO_CLK   = 3'd1,
    STAT_INTERLACED = 3'd2,
    STAT_ZERO_SIZE  = 3'd3,
    STAT_SYNC_RANGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ASPECT_NONE = 2'd0,
    ASPECT_4_3  = 2'd1,
    ASPECT_16_9 = 2'd2
  } aspect_e;

  localparam logic [6:0]  DEFAULT_HZ = 7'd50;
  localparam logic [6:0]  MIN_HZ     = 7'd24;
  localparam logic [6:0]  MAX_HZ     = 7'd120;

  // rounding bias for the kHz result
  localparam logic [9:0]  ROUND_BIAS = 10'd500;

  // x / 1000 = (x >> 3) / 125; /125 by reciprocal ceil(2^37 / 125), exact for 30-bit x
  localparam int unsigned DIV_SHIFT  = 37;
  localparam logic [30:0] DIV_RECIP  = 31'd1099511628;

  // hmm / 25 by reciprocal ceil(2^17 / 25), exact for 12-bit hmm
  localparam int unsigned TOL_SHIFT  = 17;
  localparam logic [12:0] TOL_RECIP  = 13'd5243;

  typedef struct packed {
    logic [11:0] hactive;
    logic [12:0] hsync_begin;
    logic [12:0] hsync_finish;
    logic [12:0] htotal;
    logic [11:0] vactive;
    logic [12:0] vsync_begin;
    logic [12:0] vsync_finish;
    logic [12:0] vtotal;
  } timing_t;

  typedef struct packed {
    timing_t     tim;
    logic [1:0]  pol;
    logic [11:0] wmm;
    logic [11:0] hmm;
    logic [7:0]  tol;
    logic [6:0]  hz;
    status_e     status;
  } unpack_t;

  typedef struct packed {
    timing_t     tim;
    logic [1:0]  pol;
    aspect_e     aspect;
    logic [25:0] area;
    logic [6:0]  hz;
    status_e     status;
  } area_t;

  typedef struct packed {
    timing_t     tim;
    logic [1:0]  pol;
    aspect_e     aspect;
    logic [29:0] scaled;
    status_e     status;
  } scale_t;

  typedef struct packed {
    timing_t     tim;
    logic [22:0] pclk;
    logic [1:0]  pol;
    aspect_e     aspect;
    status_e     status;
  } result_t;

endpackage

[sv/edid_detailed_timing_decode.sv]
// EDID detailed timing descriptor decoder, four-stage pipeline.
// An accepted word passes through the stage 1, 2 and 3 registers into the output register.
// Throughput: one word per cycle while not stalled; the 30x31 reciprocal multiply
// in the last stage and the 26x7 refresh multiply before it set the stage depth.
// Reset: asynchronous, active low; clears all stage valids, refresh register to 50 Hz.
// Depends on edtd_pkg.
module edid_detailed_timing_decode
  import edtd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // refresh register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_wdata_i,
  // descriptor words in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [47:0] desc_bytes_0_5_i,
  input  logic [47:0] desc_bytes_6_11_i,
  input  logic [47:0] desc_bytes_12_17_i,
  // decoded timing out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] hactive_o,
  output logic [12:0] hsync_begin_o,
  output logic [12:0] hsync_finish_o,
  output logic [12:0] htotal_o,
  output logic [11:0] vactive_o,
  output logic [12:0] vsync_begin_o,
  output logic [12:0] vsync_finish_o,
  output logic [12:0] vtotal_o,
  output logic [22:0] pixel_clock_khz_o,
  output logic [1:0]  sync_polarity_o,
  output logic [1:0]  aspect_code_o,
  output logic [2:0]  status_o
);

  // ---------------------------------------------------------------------------
  // Refresh register, always ready. The user writes it only while the pipe is empty; not enforced.
  // ---------------------------------------------------------------------------
  logic [6:0] hz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hz_q <= DEFAULT_HZ;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hz_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or the stage
  // after it moves, so bubbles collapse and a stall holds the full stages past the last bubble.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4        = !v4_q || !out_stall_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack the descriptor, run the checks, form the timing sums.
  // A rejected word has every field but status zeroed here, hz included, so the later
  // stages give a zero clock, polarity and aspect with no extra muxing.
  // ---------------------------------------------------------------------------
  logic [143:0] desc;
  logic [7:0]   b [18];
  logic [15:0]  pclk;
  logic [11:0]  ha, hb, va, vb, wmm, hmm;
  logic [9:0]   hso, hsw;
  logic [5:0]   vso, vsw;
  logic [7:0]   fl;
  logic [24:0]  tol_prod;
  logic [6:0]   hz_sel;
  status_e      status;
  unpack_t      s1_d, s1_q;

  assign desc = {desc_bytes_12_17_i, desc_bytes_6_11_i, desc_bytes_0_5_i};

  always_comb begin
    for (int k = 0; k < 18; k++) begin
      b[k] = desc[8*k +: 8];
    end
  end

  assign pclk = {b[1], b[0]};
  assign ha   = {b[4][7:4], b[2]};
  assign hb   = {b[4][3:0], b[3]};
  assign va   = {b[7][7:4], b[5]};
  assign vb   = {b[7][3:0], b[6]};
  assign hso  = {b[11][7:6], b[8]};
  assign hsw  = {b[11][5:4], b[9]};
  assign vso  = {b[11][3:2], b[10][7:4]};
  assign vsw  = {b[11][1:0], b[10][3:0]};
  assign wmm  = {b[14][7:4], b[12]};
  assign hmm  = {b[14][3:0], b[13]};
  assign fl   = b[17];

  // out-of-range refresh falls back to the default
  assign hz_sel   = (hz_q inside {[MIN_HZ:MAX_HZ]}) ? hz_q : DEFAULT_HZ;
  assign tol_prod = 25'(hmm) * 25'(TOL_RECIP);

  // first failing check wins
  always_comb begin
    if (pclk == 16'd0) begin
      status = STAT_ZERO_CLK;
    end else if (fl[7]) begin
      status = STAT_INTERLACED;
    end else if (ha == 12'd0 || va == 12'd0 || hb == 12'd0 || vb == 12'd0) begin
      status = STAT_ZERO_SIZE;
    end else if ((12'(hso) + 12'(hsw) > hb) || (12'(vso) + 12'(vsw) > vb)) begin
      status = STAT_SYNC_RANGE;
    end else begin
      status = STAT_OK;
    end
  end

  always_comb begin
    s1_d = '0;
    s1_d.status = status;
    if (status == STAT_OK) begin
      s1_d.tim.hactive      = ha;
      s1_d.tim.hsync_begin  = 13'(ha) + 13'(hso);
      s1_d.tim.hsync_finish = 13'(ha) + 13'(hso) + 13'(hsw);
      s1_d.tim.htotal       = 13'(ha) + 13'(hb);
      s1_d.tim.vactive      = va;
      s1_d.tim.vsync_begin  = 13'(va) + 13'(vso);
      s1_d.tim.vsync_finish = 13'(va) + 13'(vso) + 13'(vsw);
      s1_d.tim.vtotal       = 13'(va) + 13'(vb);
      // polarity only for digital separate sync
      s1_d.pol = (fl[4] && fl[3]) ? {fl[2], fl[1]} : 2'b11;
      s1_d.wmm = wmm;
      s1_d.hmm = hmm;
      s1_d.tol = tol_prod[TOL_SHIFT +: 8];
      s1_d.hz  = hz_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: frame area and aspect class (4:3 tested before 16:9).
  // ---------------------------------------------------------------------------
  logic [16:0] w3, w9, h4, h16;
  aspect_e     aspect;
  area_t       s2_d, s2_q;

  assign w3  = 17'(s1_q.wmm) * 17'd3;
  assign w9  = 17'(s1_q.wmm) * 17'd9;
  assign h4  = {3'b000, s1_q.hmm, 2'b00};
  assign h16 = {1'b0, s1_q.hmm, 4'b0000};

  always_comb begin
    if (s1_q.wmm == 12'd0 || s1_q.hmm == 12'd0) begin
      aspect = ASPECT_NONE;
    end else if (w3 >= h4 - 17'(s1_q.tol) && w3 <= h4 + 17'(s1_q.tol)) begin
      aspect = ASPECT_4_3;
    end else if (w9 >= h16 - 17'(s1_q.tol) && w9 <= h16 + 17'(s1_q.tol)) begin
      aspect = ASPECT_16_9;
    end else begin
      aspect = ASPECT_NONE;
    end
  end

  always_comb begin
    s2_d.tim    = s1_q.tim;
    s2_d.pol    = s1_q.pol;
    s2_d.aspect = aspect;
    s2_d.area   = 26'(s1_q.tim.htotal) * 26'(s1_q.tim.vtotal);
    s2_d.hz     = s1_q.hz;
    s2_d.status = s1_q.status;
  end

  always_ff @(posedge clk_i) begin
    if (en2) s2_q <= s2_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: area times refresh plus rounding bias; the /8 part of /1000 is
  // taken here as a shift.
  // ---------------------------------------------------------------------------
  logic [32:0] biased;
  scale_t      s3_d, s3_q;

  assign biased = 33'(s2_q.area) * 33'(s2_q.hz) + 33'(ROUND_BIAS);

  always_comb begin
    s3_d.tim    = s2_q.tim;
    s3_d.pol    = s2_q.pol;
    s3_d.aspect = s2_q.aspect;
    s3_d.scaled = biased[32:3];
    s3_d.status = s2_q.status;
  end

  always_ff @(posedge clk_i) begin
    if (en3) s3_q <= s3_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: /125 by reciprocal multiply into the output register.
  // ---------------------------------------------------------------------------
  logic [60:0] quot_prod;
  result_t     out_d, out_q;

  assign quot_prod = 61'(s3_q.scaled) * 61'(DIV_RECIP);

  always_comb begin
    out_d.tim    = s3_q.tim;
    out_d.pclk   = quot_prod[DIV_SHIFT +: 23];
    out_d.pol    = s3_q.pol;
    out_d.aspect = s3_q.aspect;
    out_d.status = s3_q.status;
  end

  always_ff @(posedge clk_i) begin
    if (en4) out_q <= out_d;
  end

  assign out_valid_o       = v4_q;
  assign hactive_o         = out_q.tim.hactive;
  assign hsync_begin_o     = out_q.tim.hsync_begin;
  assign hsync_finish_o    = out_q.tim.hsync_finish;
  assign htotal_o          = out_q.tim.htotal;
  assign vactive_o         = out_q.tim.vactive;
  assign vsync_begin_o     = out_q.tim.vsync_begin;
  assign vsync_finish_o    = out_q.tim.vsync_finish;
  assign vtotal_o          = out_q.tim.vtotal;
  assign pixel_clock_khz_o = out_q.pclk;
  assign sync_polarity_o   = out_q.pol;
  assign aspect_code_o     = out_q.aspect;
  assign status_o          = out_q.status;

endmodule

[sv/edtd_checker.sv]
// Port-level checker for the EDID timing decoder, bound to the top level.
// Depends on edtd_pkg and edid_detailed_timing_decode_defines.svh.
`include "edid_detailed_timing_decode_defines.svh"

module edtd_checker
  import edtd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] hactive_o,
  input logic [12:0] hsync_begin_o,
  input logic [12:0] hsync_finish_o,
  input logic [12:0] htotal_o,
  input logic [11:0] vactive_o,
  input logic [12:0] vsync_begin_o,
  input logic [12:0] vsync_finish_o,
  input logic [12:0] vtotal_o,
  input logic [22:0] pixel_clock_khz_o,
  input logic [1:0]  sync_polarity_o,
  input logic [1:0]  aspect_code_o,
  input logic [2:0]  status_o
);

  // a stalled result word stays put
  `EDTD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(htotal_o) && $stable(pixel_clock_khz_o) && $stable(status_o))

  // rejected words carry no timing
  `EDTD_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, out_valid_o && status_o != STAT_OK, hactive_o == 12'd0 && vtotal_o == 13'd0 && pixel_clock_khz_o == 23'd0 && sync_polarity_o == 2'd0 && aspect_code_o == ASPECT_NONE)

  // accepted words: hsync lies inside blanking, vsync ends by the total, totals exceed active
  `EDTD_ASSERT_IMP(a_sync_order, clk_i, rst_ni, out_valid_o && status_o == STAT_OK, hsync_begin_o >= 13'(hactive_o) && hsync_finish_o >= hsync_begin_o && hsync_finish_o <= htotal_o && htotal_o > 13'(hactive_o) && vsync_finish_o >= vsync_begin_o && vsync_finish_o <= vtotal_o && vtotal_o > 13'(vactive_o))

  // codes stay in their defined range
  `EDTD_ASSERT_IMP(a_codes, clk_i, rst_ni, out_valid_o, aspect_code_o != 2'd3 && status_o <= STAT_SYNC_RANGE)

endmodule

bind edid_detailed_timing_decode edtd_checker u_edtd_checker (.*);
